// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the hazard tracker, included by aht_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/aht_pkg.sv
// Types, constants and codes of the access hazard tracker.
package aht_pkg;

   parameter int BUF_ENTRIES = 32;
   parameter int IMG_ENTRIES = 16;

   localparam int RES_W   = 32;
   localparam int RANGE_W = 40;
   localparam int STAGE_W = 4;
   localparam int USAGE_W = 2;
   localparam int MODE_W  = 2;

   localparam int BUF_IDX_W  = (BUF_ENTRIES > 1) ? $clog2(BUF_ENTRIES) : 1;
   localparam int IMG_IDX_W  = (IMG_ENTRIES > 1) ? $clog2(IMG_ENTRIES) : 1;
   localparam int BUF_CNT_W  = $clog2(BUF_ENTRIES + 1);
   localparam int IMG_CNT_W  = $clog2(IMG_ENTRIES + 1);
   localparam int SCAN_CNT_W = (BUF_CNT_W > IMG_CNT_W) ? BUF_CNT_W : IMG_CNT_W;

   localparam logic [MODE_W-1:0] MODE_BUFFER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IMAGE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [RES_W-1:0]   res;
      logic [RANGE_W-1:0] off;
      logic [RANGE_W-1:0] len;
      logic [STAGE_W-1:0] stage;
      logic               rd;
      logic               wr;
   } buf_rec_type;

   typedef struct packed {
      logic [RES_W-1:0]   res;
      logic [STAGE_W-1:0] stage;
      logic               rd;
      logic               wr;
      logic [USAGE_W-1:0] usage;
   } img_rec_type;

   localparam int BUF_REC_W = $bits(buf_rec_type);
   localparam int IMG_REC_W = $bits(img_rec_type);

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [RES_W-1:0]   res;
      logic [RANGE_W-1:0] off;
      logic [RANGE_W-1:0] len;
      logic [STAGE_W-1:0] stage;
      logic               rd;
      logic               wr;
      logic [USAGE_W-1:0] usage;
   } req_type;

   typedef struct packed {
      logic               hazard;
      logic [STAGE_W-1:0] prev_stage;
      logic               prev_read;
      logic               prev_write;
      logic [USAGE_W-1:0] prev_usage;
      logic               anti_dep;
      logic               table_full;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

// File: hw/rtl/aht_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module aht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/aht_engine.sv
// Scan, hazard check, write-back and append sequencer over the buffer and image tables; clear empties both.
`include "assert_macros.svh"

module aht_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  aht_pkg::req_type        req,
   input  logic                    take,
   output aht_pkg::eng_status_type status,
   output aht_pkg::rsp_type        rslt
);

   aht_pkg::state_type  state_ff, state_in;
   aht_pkg::req_type    req_ff, req_in;
   logic [aht_pkg::RANGE_W:0]      nend_ff, nend_in;
   logic [aht_pkg::SCAN_CNT_W-1:0] scan_ff, scan_in;
   logic [aht_pkg::SCAN_CNT_W-1:0] chk_ff, chk_in;
   logic [aht_pkg::SCAN_CNT_W-1:0] hidx_ff, hidx_in;
   logic                           pend_ff, pend_in;
   logic [aht_pkg::BUF_CNT_W-1:0]  bfill_ff, bfill_in;
   logic [aht_pkg::IMG_CNT_W-1:0]  ifill_ff, ifill_in;
   aht_pkg::buf_rec_type bhit_ff, bhit_in;
   aht_pkg::img_rec_type ihit_ff, ihit_in;
   aht_pkg::rsp_type     rslt_ff, rslt_in;

   logic                           b_wr_en, b_rd_en, i_wr_en, i_rd_en;
   logic [aht_pkg::BUF_IDX_W-1:0]  b_wr_addr;
   logic [aht_pkg::IMG_IDX_W-1:0]  i_wr_addr;
   aht_pkg::buf_rec_type           b_wr_rec, brd;
   aht_pkg::img_rec_type           i_wr_rec, ird;
   logic [aht_pkg::BUF_REC_W-1:0]  brd_raw;
   logic [aht_pkg::IMG_REC_W-1:0]  ird_raw;

   logic                           is_img;
   logic [aht_pkg::SCAN_CNT_W-1:0] fill_sel;
   logic                           issue;
   logic [aht_pkg::RANGE_W:0]      e_end, h_end, hi;
   logic [aht_pkg::RANGE_W-1:0]    lo;
   logic [aht_pkg::RANGE_W:0]      ilen;
   logic                           hit_b, hit_i, hit;

   aht_ram #(
      .WIDTH (aht_pkg::BUF_REC_W),
      .DEPTH (aht_pkg::BUF_ENTRIES)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_rec),
      .rd_en   (b_rd_en),
      .rd_addr (scan_ff[aht_pkg::BUF_IDX_W-1:0]),
      .rd_data (brd_raw)
   );

   aht_ram #(
      .WIDTH (aht_pkg::IMG_REC_W),
      .DEPTH (aht_pkg::IMG_ENTRIES)
   ) u_img_ram (
      .clock   (clock),
      .wr_en   (i_wr_en),
      .wr_addr (i_wr_addr),
      .wr_data (i_wr_rec),
      .rd_en   (i_rd_en),
      .rd_addr (scan_ff[aht_pkg::IMG_IDX_W-1:0]),
      .rd_data (ird_raw)
   );

   assign brd = aht_pkg::buf_rec_type'(brd_raw);
   assign ird = aht_pkg::img_rec_type'(ird_raw);

   assign is_img   = (req_ff.mode == aht_pkg::MODE_IMAGE);
   assign fill_sel = is_img ? aht_pkg::SCAN_CNT_W'(ifill_ff) : aht_pkg::SCAN_CNT_W'(bfill_ff);
   assign issue    = (scan_ff < fill_sel);

   assign e_end = {1'b0, brd.off} + {1'b0, brd.len};
   assign hit_b = (req_ff.wr | brd.wr) && (brd.res == req_ff.res) &&
                  (((req_ff.off >= brd.off) && ({1'b0, req_ff.off} < e_end)) ||
                   ((brd.off >= req_ff.off) && ({1'b0, brd.off} < nend_ff)));
   assign hit_i = (req_ff.wr | ird.wr) && (ird.res == req_ff.res);
   assign hit   = is_img ? hit_i : hit_b;

   assign h_end = {1'b0, bhit_ff.off} + {1'b0, bhit_ff.len};
   assign lo    = (bhit_ff.off >= req_ff.off) ? bhit_ff.off : req_ff.off;
   assign hi    = (nend_ff < h_end) ? nend_ff : h_end;
   assign ilen  = hi - {1'b0, lo};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aht_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         bfill_ff <= '0;
         ifill_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         bfill_ff <= bfill_in;
         ifill_ff <= ifill_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      nend_ff <= nend_in;
      scan_ff <= scan_in;
      chk_ff  <= chk_in;
      hidx_ff <= hidx_in;
      bhit_ff <= bhit_in;
      ihit_ff <= ihit_in;
      rslt_ff <= rslt_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      nend_in   = nend_ff;
      scan_in   = scan_ff;
      chk_in    = chk_ff;
      hidx_in   = hidx_ff;
      pend_in   = pend_ff;
      bfill_in  = bfill_ff;
      ifill_in  = ifill_ff;
      bhit_in   = bhit_ff;
      ihit_in   = ihit_ff;
      rslt_in   = rslt_ff;
      b_wr_en   = 1'b0;
      i_wr_en   = 1'b0;
      b_rd_en   = 1'b0;
      i_rd_en   = 1'b0;
      b_wr_addr = bfill_ff[aht_pkg::BUF_IDX_W-1:0];
      i_wr_addr = ifill_ff[aht_pkg::IMG_IDX_W-1:0];
      b_wr_rec  = '{res: req_ff.res, off: req_ff.off, len: req_ff.len,
                    stage: req_ff.stage, rd: req_ff.rd, wr: req_ff.wr};
      i_wr_rec  = '{res: req_ff.res, stage: req_ff.stage, rd: req_ff.rd,
                    wr: req_ff.wr, usage: req_ff.usage};
      status    = '{idle: 1'b0, done: 1'b0};

      case (state_ff)
         aht_pkg::ST_IDLE: begin
            status.idle = 1'b1;
            if (start) begin
               req_in  = req;
               nend_in = {1'b0, req.off} + {1'b0, req.len};
               scan_in = '0;
               pend_in = 1'b0;
               rslt_in = '0;
               case (req.mode)
                  aht_pkg::MODE_BUFFER, aht_pkg::MODE_IMAGE: begin
                     state_in = aht_pkg::ST_SCAN;
                  end
                  aht_pkg::MODE_CLEAR: begin
                     bfill_in = '0;
                     ifill_in = '0;
                     state_in = aht_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = aht_pkg::ST_DONE;
                  end
               endcase
            end
         end
         aht_pkg::ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               b_rd_en = ~is_img;
               i_rd_en = is_img;
               chk_in  = scan_ff;
               scan_in = scan_ff + aht_pkg::SCAN_CNT_W'(1);
            end
            if (pend_ff) begin
               if (hit) begin
                  bhit_in  = brd;
                  ihit_in  = ird;
                  hidx_in  = chk_ff;
                  pend_in  = 1'b0;
                  state_in = aht_pkg::ST_HIT;
               end
            end else if (!issue) begin
               state_in = aht_pkg::ST_DONE;
               if (is_img) begin
                  if (ifill_ff < aht_pkg::IMG_CNT_W'(aht_pkg::IMG_ENTRIES)) begin
                     i_wr_en  = 1'b1;
                     ifill_in = ifill_ff + aht_pkg::IMG_CNT_W'(1);
                  end else begin
                     rslt_in.table_full = 1'b1;
                  end
               end else begin
                  if (bfill_ff < aht_pkg::BUF_CNT_W'(aht_pkg::BUF_ENTRIES)) begin
                     b_wr_en  = 1'b1;
                     bfill_in = bfill_ff + aht_pkg::BUF_CNT_W'(1);
                  end else begin
                     rslt_in.table_full = 1'b1;
                  end
               end
            end
         end
         aht_pkg::ST_HIT: begin
            b_wr_addr = hidx_ff[aht_pkg::BUF_IDX_W-1:0];
            i_wr_addr = hidx_ff[aht_pkg::IMG_IDX_W-1:0];
            b_wr_rec.off = lo;
            b_wr_rec.len = ilen[aht_pkg::RANGE_W-1:0];
            rslt_in.hazard = 1'b1;
            if (is_img) begin
               i_wr_en            = 1'b1;
               i_wr_rec.res       = ihit_ff.res;
               rslt_in.prev_stage = ihit_ff.stage;
               rslt_in.prev_read  = ihit_ff.rd;
               rslt_in.prev_write = ihit_ff.wr;
               rslt_in.prev_usage = ihit_ff.usage;
               rslt_in.anti_dep   = ihit_ff.rd & ~ihit_ff.wr & req_ff.wr;
            end else begin
               b_wr_en            = 1'b1;
               rslt_in.prev_stage = bhit_ff.stage;
               rslt_in.prev_read  = bhit_ff.rd;
               rslt_in.prev_write = bhit_ff.wr;
               rslt_in.prev_usage = '0;
               rslt_in.anti_dep   = bhit_ff.rd & ~bhit_ff.wr & req_ff.wr;
            end
            state_in = aht_pkg::ST_DONE;
         end
         aht_pkg::ST_DONE: begin
            status.done = 1'b1;
            if (take) begin
               state_in = aht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aht_pkg::ST_IDLE;
         end
      endcase
   end

   assign rslt = rslt_ff;

   `ASSERT_CLKD(a_bfill_bound, clock, reset, bfill_ff <= aht_pkg::BUF_CNT_W'(aht_pkg::BUF_ENTRIES), "buffer fill beyond table depth")
   `ASSERT_CLKD(a_ifill_bound, clock, reset, ifill_ff <= aht_pkg::IMG_CNT_W'(aht_pkg::IMG_ENTRIES), "image fill beyond table depth")
   `ASSERT_CLKD(a_hit_from_scan, clock, reset, state_ff == aht_pkg::ST_HIT |-> $past(state_ff) == aht_pkg::ST_SCAN, "write-back without a scan hit")
   `ASSERT_CLKD(a_pend_from_scan, clock, reset, pend_ff |-> $past(state_ff) == aht_pkg::ST_SCAN, "table read in flight outside a scan")
   `ASSERT_NEVER(a_hazard_and_full, clock, reset, state_ff == aht_pkg::ST_DONE && rslt_ff.hazard && rslt_ff.table_full, "hazard and table full reported together")

endmodule

// File: hw/rtl/access_hazard_tracker_unit.sv
// Top level of the access hazard tracker: stream ports, request unpack, result register.
//
//  channel  dir   handshake              payload
//  req_     in    req_tvalid/req_tready  req_tuser mode, req_tdata access fields
//  rsp_     out   rsp_tvalid/rsp_tready  rsp_tdata hazard result
//
// An access scans the table one entry per cycle through the single read port of its RAM,
// and a hazard write-back updates the hit entry in place of the append.
// Clear and the unused mode go straight to the done state. One access is in work at a time.
// A finished result waits in the output register while the next access is taken.
// Synchronous reset empties both tables at once through their fill counts.
module access_hazard_tracker_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] resource_id, [71:32] range_offset, [111:72] range_size,
   // [115:112] access_stage, [116] is_read, [117] is_write, [119:118] image_usage
   input  logic [119:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] hazard, [4:1] prev_stage, [5] prev_read, [6] prev_write,
   // [8:7] prev_usage, [9] anti_dep, [10] table_full, [15:11] zero
   output logic [15:0]  rsp_tdata
);

   aht_pkg::req_type        req;
   aht_pkg::eng_status_type status;
   aht_pkg::rsp_type        rslt;
   logic                    start, take;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_data_ff;

   assign req.mode  = req_tuser;
   assign req.res   = req_tdata[31:0];
   assign req.off   = req_tdata[71:32];
   assign req.len   = req_tdata[111:72];
   assign req.stage = req_tdata[115:112];
   assign req.rd    = req_tdata[116];
   assign req.wr    = req_tdata[117];
   assign req.usage = req_tdata[119:118];

   assign req_tready = status.idle;
   assign start      = req_tvalid & status.idle;
   assign take       = status.done & (~rsp_valid_ff | rsp_tready);

   aht_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req),
      .take   (take),
      .status (status),
      .rslt   (rslt)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= {5'b0, rslt.table_full, rslt.anti_dep, rslt.prev_usage,
                         rslt.prev_write, rslt.prev_read, rslt.prev_stage, rslt.hazard};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
